### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define EPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define EPG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `EPG_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### hdl/epg_pkg.sv
// Shared widths, defaults and action codes of the ellipse point generator.
// Depends on nothing; used by the top level and its checker.
`timescale 1ns / 1ps

package epg_pkg;

  localparam int AXIS_W       = 10;
  localparam int AXIS_MAX     = (2 ** AXIS_W) - 1;
  localparam int PT_W         = 11;
  localparam int SQ_W         = 2 * AXIS_W;
  localparam int ERR_W        = 40;
  localparam int MAX_AXIS_DEF = 1023;

  typedef enum logic {
    ACT_START   = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

endpackage

### hdl/ellipse_point_generator_top.sv
// Two-error-term ellipse walk with one shared multiplier and one shared adder.
// Depends on epg_pkg.
//
// channel  direction  handshake               payload
// in       to block   in_valid_i / in_stall_o  action_i, semi_axis_x_i, semi_axis_y_i
// out      from block out_valid_o / out_stall_i point_x_o, point_y_o, finished_o, last_o
//
// A start or a running advance holds in_stall_o high after its transfer through four multiplier
// passes, each product used in the cycle after its pass; the next transfer waits for both.
// The four mirrored points leave alongside, one per cycle unless out_stall_i holds them; output
// stalls can lengthen in_stall_o. An advance after the walk finished is taken and gives no points.
// Reset clears the sequencer, the running flag and the output valid; no clearing pass.
`timescale 1ns / 1ps

module ellipse_point_generator_top #(
  parameter int MAX_AXIS = epg_pkg::MAX_AXIS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [epg_pkg::AXIS_W-1:0]        semi_axis_x_i,
  input  logic [epg_pkg::AXIS_W-1:0]        semi_axis_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [epg_pkg::PT_W-1:0]   point_x_o,
  output logic signed [epg_pkg::PT_W-1:0]   point_y_o,
  output logic                              finished_o,
  output logic                              last_o
);

  localparam int AXIS_W   = epg_pkg::AXIS_W;
  localparam int PT_W     = epg_pkg::PT_W;
  localparam int SQ_W     = epg_pkg::SQ_W;
  localparam int ERR_W    = epg_pkg::ERR_W;
  localparam int COL_W    = $clog2(MAX_AXIS + 1);
  localparam int MB_W     = (COL_W + 3 > 12) ? COL_W + 3 : 12;
  localparam int PRD_W    = SQ_W + 1 + MB_W;
  localparam int AXIS_CAP = (MAX_AXIS < epg_pkg::AXIS_MAX) ? MAX_AXIS : epg_pkg::AXIS_MAX;

  localparam logic [AXIS_W-1:0] AXIS_CAP_V = AXIS_W'(AXIS_CAP);
  localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(MAX_AXIS);

  localparam logic [1:0] OP_P1 = 2'd0;
  localparam logic [1:0] OP_P2 = 2'd1;
  localparam logic [1:0] OP_P3 = 2'd2;
  localparam logic [1:0] OP_P4 = 2'd3;

  localparam logic [1:0] QD_PP = 2'd0;
  localparam logic [1:0] QD_NP = 2'd1;
  localparam logic [1:0] QD_NN = 2'd2;
  localparam logic [1:0] QD_PN = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  typedef enum logic [1:0] {
    BR_X,
    BR_XY,
    BR_Y
  } branch_e;

  state_e                    state_q;
  logic                      issue_q;
  logic [1:0]                op_q;
  logic                      prod_vld_q;
  logic [1:0]                tag_q;
  logic                      emit_q;
  logic [1:0]                quad_q;
  logic                      running_q;
  logic                      fin_q;

  epg_pkg::action_e          mode_q;
  branch_e                   br_q;
  branch_e                   br_d;
  logic [COL_W-1:0]          opx_q;
  logic [AXIS_W-1:0]         opy_q;
  logic [COL_W-1:0]          col_q;
  logic [COL_W-1:0]          col_d;
  logic [AXIS_W-1:0]         row_q;
  logic [AXIS_W-1:0]         row_d;
  logic [SQ_W-1:0]           a2_q;
  logic [SQ_W-1:0]           b2_q;
  logic [ERR_W-1:0]          err_s_q;
  logic [ERR_W-1:0]          err_t_q;
  logic signed [PRD_W-1:0]   prod_q;
  logic signed [PRD_W-1:0]   prod_d;

  logic                      in_xfer;
  logic                      out_xfer;
  logic                      is_start;
  logic [AXIS_W-1:0]         a_clamp;
  logic [AXIS_W-1:0]         b_clamp;
  logic [SQ_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [ERR_W-1:0]          prod_ext;
  logic [ERR_W-1:0]          b2_ext;
  logic [ERR_W-1:0]          acc_base;
  logic [ERR_W-1:0]          acc_addend;
  logic                      acc_sub;
  logic [ERR_W-1:0]          acc_sum;
  logic                      wr_s;
  logic                      wr_t;
  logic                      wr_a2;
  logic                      wr_b2;
  logic [PT_W-1:0]           x_pt;
  logic [PT_W-1:0]           y_pt;

  assign in_stall_o = (state_q != ST_IDLE) || emit_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = emit_q && !out_stall_i;
  assign is_start   = (action_i == epg_pkg::ACT_START);

  assign a_clamp = (semi_axis_x_i > AXIS_CAP_V) ? AXIS_CAP_V : semi_axis_x_i;
  assign b_clamp = (semi_axis_y_i > AXIS_CAP_V) ? AXIS_CAP_V : semi_axis_y_i;

  // Step choice from the signs of S and T, and the new position.
  always_comb begin
    if (err_s_q[ERR_W-1]) begin
      br_d = BR_X;
    end else if (err_t_q[ERR_W-1]) begin
      br_d = BR_XY;
    end else begin
      br_d = BR_Y;
    end
    col_d = col_q;
    row_d = row_q;
    if (br_d != BR_Y && col_q < COL_MAX) begin
      col_d = col_q + COL_W'(1);
    end
    if (br_d != BR_X && row_q != '0) begin
      row_d = row_q - AXIS_W'(1);
    end
  end

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (mode_q == epg_pkg::ACT_START) begin
      case (op_q)
        OP_P1: begin
          mul_a = SQ_W'(opx_q);
          mul_b = MB_W'(opx_q);
        end
        OP_P2: begin
          mul_a = SQ_W'(opy_q);
          mul_b = MB_W'(opy_q);
        end
        default: begin
          mul_a = a2_q;
          mul_b = MB_W'({opy_q, 1'b0}) - MB_W'(1);
        end
      endcase
    end else begin
      case (op_q)
        OP_P1: begin
          mul_a = b2_q;
          mul_b = MB_W'({opx_q, 1'b0}) + MB_W'(3);
        end
        OP_P2: begin
          mul_a = b2_q;
          mul_b = MB_W'(opx_q) + MB_W'(1);
        end
        OP_P3: begin
          mul_a = a2_q;
          mul_b = MB_W'(opy_q) - MB_W'(1);
        end
        default: begin
          mul_a = a2_q;
          mul_b = MB_W'({opy_q, 1'b0}) - MB_W'(3);
        end
      endcase
    end
  end

  assign prod_d = $signed({1'b0, mul_a}) * $signed(mul_b);

  assign prod_ext = {{(ERR_W - PRD_W){prod_q[PRD_W-1]}}, prod_q};
  assign b2_ext   = ERR_W'(b2_q);

  // Shared add/subtract into the error terms.
  always_comb begin
    acc_base   = err_s_q;
    acc_addend = prod_ext;
    acc_sub    = 1'b0;
    wr_s       = 1'b0;
    wr_t       = 1'b0;
    wr_a2      = 1'b0;
    wr_b2      = 1'b0;
    if (prod_vld_q) begin
      if (mode_q == epg_pkg::ACT_START) begin
        case (tag_q)
          OP_P1: wr_a2 = 1'b1;
          OP_P2: wr_b2 = 1'b1;
          OP_P3: begin
            acc_base   = b2_ext << 1;
            acc_addend = prod_ext;
            acc_sub    = 1'b1;
            wr_s       = 1'b1;
          end
          default: begin
            acc_base   = b2_ext;
            acc_addend = prod_ext << 1;
            acc_sub    = 1'b1;
            wr_t       = 1'b1;
          end
        endcase
      end else begin
        case (tag_q)
          OP_P1: begin
            acc_base   = err_s_q;
            acc_addend = prod_ext << 1;
            wr_s       = (br_q != BR_Y);
          end
          OP_P2: begin
            acc_base   = err_t_q;
            acc_addend = prod_ext << 2;
            wr_t       = (br_q != BR_Y);
          end
          OP_P3: begin
            acc_base   = err_s_q;
            acc_addend = prod_ext << 2;
            acc_sub    = 1'b1;
            wr_s       = (br_q != BR_X);
          end
          default: begin
            acc_base   = err_t_q;
            acc_addend = prod_ext << 1;
            acc_sub    = 1'b1;
            wr_t       = (br_q != BR_X);
          end
        endcase
      end
    end
  end

  assign acc_sum = acc_sub ? (acc_base - acc_addend) : (acc_base + acc_addend);

  // Sequencer, running flag and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issue_q    <= 1'b0;
      op_q       <= OP_P1;
      prod_vld_q <= 1'b0;
      tag_q      <= OP_P1;
      emit_q     <= 1'b0;
      quad_q     <= QD_PP;
      running_q  <= 1'b0;
    end else begin
      prod_vld_q <= issue_q;
      if (issue_q) begin
        tag_q <= op_q;
        op_q  <= op_q + 2'd1;
        if (op_q == OP_P4) begin
          issue_q <= 1'b0;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && (is_start || running_q)) begin
            state_q <= ST_CALC;
            issue_q <= 1'b1;
            op_q    <= OP_P1;
            emit_q  <= 1'b1;
            quad_q  <= QD_PP;
            if (is_start) begin
              running_q <= (b_clamp != '0);
            end else begin
              running_q <= (row_d != '0);
            end
          end
        end
        ST_CALC: begin
          if (prod_vld_q && tag_q == OP_P4) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (out_xfer) begin
        quad_q <= quad_q + 2'd1;
        if (quad_q == QD_PN) begin
          emit_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer && is_start) begin
      mode_q <= epg_pkg::ACT_START;
      opx_q  <= COL_W'(a_clamp);
      opy_q  <= b_clamp;
      col_q  <= '0;
      row_q  <= b_clamp;
      fin_q  <= (b_clamp == '0);
    end else if (in_xfer && running_q) begin
      mode_q <= epg_pkg::ACT_ADVANCE;
      br_q   <= br_d;
      opx_q  <= col_q;
      opy_q  <= row_q;
      col_q  <= col_d;
      row_q  <= row_d;
      fin_q  <= (row_d == '0);
    end
    if (issue_q) begin
      prod_q <= prod_d;
    end
    if (wr_a2) begin
      a2_q <= prod_q[SQ_W-1:0];
    end
    if (wr_b2) begin
      b2_q <= prod_q[SQ_W-1:0];
    end
    if (wr_s) begin
      err_s_q <= acc_sum;
    end
    if (wr_t) begin
      err_t_q <= acc_sum;
    end
  end

  assign x_pt = PT_W'(col_q);
  assign y_pt = PT_W'(row_q);

  assign out_valid_o = emit_q;
  assign point_x_o   = $signed((quad_q == QD_NP || quad_q == QD_NN) ?
                               (~x_pt + PT_W'(1)) : x_pt);
  assign point_y_o   = $signed((quad_q == QD_NN || quad_q == QD_PN) ?
                               (~y_pt + PT_W'(1)) : y_pt);
  assign finished_o  = fin_q;
  assign last_o      = (quad_q == QD_PN);

endmodule

### hdl/epg_checker.sv
// Port-level checks on the ellipse point generator, bound to its top level.
// Depends on epg_pkg and assert_macros.svh.
`include "assert_macros.svh"
`timescale 1ns / 1ps

module epg_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              action_i,
  input logic [epg_pkg::AXIS_W-1:0]        semi_axis_x_i,
  input logic [epg_pkg::AXIS_W-1:0]        semi_axis_y_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [epg_pkg::PT_W-1:0]   point_x_o,
  input logic signed [epg_pkg::PT_W-1:0]   point_y_o,
  input logic                              finished_o,
  input logic                              last_o
);

  logic in_xfer;
  logic out_xfer;
  logic start_xfer;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_o && !out_stall_i;
  assign start_xfer = in_xfer && (action_i == epg_pkg::ACT_START) &&
                      (semi_axis_x_i == semi_axis_x_i) && (semi_axis_y_i == semi_axis_y_i);

  `EPG_ASSERT_NEVER(a_no_input_while_emitting, clk_i, rst_ni, out_valid_o && !in_stall_o, "input ready while points pending")
  `EPG_ASSERT(a_start_emits_origin_column, clk_i, rst_ni, start_xfer |=> (out_valid_o && !last_o && point_x_o == '0), "start did not emit first point on x = 0")
  `EPG_ASSERT(a_last_ends_group, clk_i, rst_ni, (out_xfer && last_o) |=> !out_valid_o, "points continue after last")
  `EPG_ASSERT(a_group_continues, clk_i, rst_ni, (out_xfer && !last_o) |=> (out_valid_o && $stable(finished_o)), "point group cut short")
  `EPG_ASSERT(a_stalled_point_holds, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(point_x_o) && $stable(point_y_o)), "stalled point changed")

endmodule

bind ellipse_point_generator_top epg_checker u_epg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .semi_axis_x_i (semi_axis_x_i),
  .semi_axis_y_i (semi_axis_y_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .point_x_o     (point_x_o),
  .point_y_o     (point_y_o),
  .finished_o    (finished_o),
  .last_o        (last_o)
);

### bench/testbench.sv
// Testbench for ellipse_point_generator_top: drives start and advance transfers and checks
// every mirrored point against an in-bench model of the two-error-term ellipse walk.
// Depends on epg_pkg and the ellipse_point_generator_top RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int PT_W         = epg_pkg::PT_W;
  localparam int AXIS_W       = epg_pkg::AXIS_W;
  localparam int ERR_W        = epg_pkg::ERR_W;
  localparam int MAX_AXIS_DEF = epg_pkg::MAX_AXIS_DEF;

  localparam logic [AXIS_W-1:0] AXIS_TOP = AXIS_W'(epg_pkg::AXIS_MAX);

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   fin;
    logic                   lst;
  } ellipse_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = epg_pkg::ACT_START;
  logic [AXIS_W-1:0] semi_axis_x_i = '0;
  logic [AXIS_W-1:0] semi_axis_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PT_W-1:0] point_x_o;
  logic signed [PT_W-1:0] point_y_o;
  logic finished_o;
  logic last_o;

  // model state of the walk
  logic [AXIS_W-1:0] walk_col = '0;
  logic [AXIS_W-1:0] walk_row = '0;
  logic signed [ERR_W-1:0] err_s_q = '0;
  logic signed [ERR_W-1:0] err_t_q = '0;
  longint a_sq = 0;
  longint b_sq = 0;
  bit walk_active = 1'b0;

  ellipse_point_t expected_points[$];
  ellipse_point_t head_point;
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  ellipse_point_generator_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .action_i(action_i),
    .semi_axis_x_i(semi_axis_x_i),
    .semi_axis_y_i(semi_axis_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .point_x_o(point_x_o),
    .point_y_o(point_y_o),
    .finished_o(finished_o),
    .last_o(last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void push_mirrors(bit fin);
    longint sx[4];
    longint sy[4];
    longint x;
    longint y;
    ellipse_point_t pt;
    x = walk_col;
    y = walk_row;
    sx = '{x, -x, -x, x};
    sy = '{y, y, -y, -y};
    for (int k = 0; k < 4; k++) begin
      pt.px = sx[k][PT_W-1:0];
      pt.py = sy[k][PT_W-1:0];
      pt.fin = fin;
      pt.lst = (k == 3);
      expected_points.push_back(pt);
    end
  endfunction

  function automatic int predict_walk(epg_pkg::action_e act, logic [AXIS_W-1:0] ax,
                                      logic [AXIS_W-1:0] ay);
    longint a;
    longint b;
    longint x;
    longint y;
    longint s;
    longint t;
    if (act == epg_pkg::ACT_START) begin
      a = (ax > MAX_AXIS_DEF) ? MAX_AXIS_DEF : ax;
      b = (ay > MAX_AXIS_DEF) ? MAX_AXIS_DEF : ay;
      a_sq = a * a;
      b_sq = b * b;
      walk_col = '0;
      walk_row = b[AXIS_W-1:0];
      s = a_sq * (1 - 2 * b) + 2 * b_sq;
      t = b_sq - 2 * a_sq * (2 * b - 1);
      err_s_q = s[ERR_W-1:0];
      err_t_q = t[ERR_W-1:0];
      walk_active = (b > 0);
      push_mirrors(!walk_active);
      return 4;
    end
    if (!walk_active) return 0;
    x = walk_col;
    y = walk_row;
    s = err_s_q;
    t = err_t_q;
    if (s < 0) begin
      s += 2 * b_sq * (2 * x + 3);
      t += 4 * b_sq * (x + 1);
      if (walk_col < MAX_AXIS_DEF) walk_col++;
    end else if (t < 0) begin
      s += 2 * b_sq * (2 * x + 3) - 4 * a_sq * (y - 1);
      t += 4 * b_sq * (x + 1) - 2 * a_sq * (2 * y - 3);
      if (walk_col < MAX_AXIS_DEF) walk_col++;
      if (walk_row > 0) walk_row--;
    end else begin
      s -= 4 * a_sq * (y - 1);
      t -= 2 * a_sq * (2 * y - 3);
      if (walk_row > 0) walk_row--;
    end
    err_s_q = s[ERR_W-1:0];
    err_t_q = t[ERR_W-1:0];
    if (walk_row == 0) walk_active = 1'b0;
    push_mirrors(walk_row == 0);
    return 4;
  endfunction

  // hold valid and payload until the transfer, then predict
  task automatic send_item(input epg_pkg::action_e act, input logic [AXIS_W-1:0] ax,
                           input logic [AXIS_W-1:0] ay, output int produced);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    semi_axis_x_i <= ax;
    semi_axis_y_i <= ay;
    do @(posedge clk_i); while (in_stall_o);
    produced = predict_walk(act, ax, ay);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_points.size() != 0);
  endtask

  // start, then advance until finished or max_steps advances
  task automatic run_walk(input logic [AXIS_W-1:0] ax, input logic [AXIS_W-1:0] ay,
                          input int max_steps, output int made);
    int produced;
    int steps;
    made = 0;
    steps = 0;
    send_item(epg_pkg::ACT_START, ax, ay, produced);
    made += int'(produced > 0);
    while (walk_active && steps < max_steps) begin
      send_item(epg_pkg::ACT_ADVANCE, AXIS_W'($urandom), AXIS_W'($urandom), produced);
      made += int'(produced > 0);
      steps++;
    end
  endtask

  function automatic logic [AXIS_W-1:0] pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 85) return AXIS_W'($urandom_range(1, 12));
    if (r < 97) return AXIS_W'($urandom_range(13, 60));
    return AXIS_W'($urandom_range(61, 200));
  endfunction

  task automatic test_axis_extremes();
    int made;
    run_walk(AXIS_TOP, AXIS_TOP, 3, made);
    run_walk(AXIS_TOP, 1, 2, made);
  endtask

  task automatic test_degenerate_axes();
    int made;
    int produced;
    run_walk(0, 3, 10, made);
    send_item(epg_pkg::ACT_ADVANCE, AXIS_TOP, AXIS_TOP, produced);
    run_walk(5, 0, 10, made);
    send_item(epg_pkg::ACT_ADVANCE, 0, 0, produced);
    run_walk(0, 0, 10, made);
    run_walk(1, 1, 10, made);
    send_item(epg_pkg::ACT_ADVANCE, AXIS_W'($urandom), AXIS_W'($urandom), produced);
  endtask

  task automatic test_restart();
    int made;
    int produced;
    run_walk(7, 5, 2, made);
    run_walk(3, 9, 2, made);
    run_walk(512, 341, 1, made);
    pause_until_drained();
    send_item(epg_pkg::ACT_ADVANCE, AXIS_W'($urandom), AXIS_W'($urandom), produced);
  endtask

  task automatic test_random_walks(input int target);
    int made;
    int produced;
    int n;
    int cut;
    n = 0;
    while (n < target) begin
      if ($urandom_range(0, 99) < 10) begin
        send_item(epg_pkg::action_e'($urandom_range(0, 1)), pick_axis(), pick_axis(),
                  produced);
        n += int'(produced > 0);
      end else begin
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 1 << 20;
        run_walk(pick_axis(), pick_axis(), cut, made);
        n += made;
        if (!walk_active) begin
          repeat ($urandom_range(0, 2)) begin
            send_item(epg_pkg::ACT_ADVANCE, AXIS_W'($urandom), AXIS_W'($urandom),
                      produced);
          end
        end
      end
      if ($urandom_range(0, 99) < 5) pause_until_drained();
    end
  endtask

  task automatic test_wide_walks();
    int made;
    run_walk(AXIS_TOP, 1, 10, made);
    run_walk(1, AXIS_TOP, 10, made);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d) fin=%0b last=%0b",
                                    point_x_o, point_y_o, finished_o, last_o));
        end else begin
          head_point = expected_points.pop_front();
          if (point_x_o !== head_point.px || point_y_o !== head_point.py ||
              finished_o !== head_point.fin || last_o !== head_point.lst) begin
            report_mismatch($sformatf(
                "got (%0d,%0d) fin=%0b last=%0b, want (%0d,%0d) fin=%0b last=%0b",
                point_x_o, point_y_o, finished_o, last_o,
                head_point.px, head_point.py, head_point.fin, head_point.lst));
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 15;
    recv_idle_pct = 59;
    test_axis_extremes();
    test_degenerate_axes();
    test_restart();
    test_random_walks(45);

    send_idle_pct = 59;
    recv_idle_pct = 15;
    test_random_walks(45);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walks(35);
    test_wide_walks();

    pause_until_drained();
    repeat (20) @(posedge clk_i);
    if (expected_points.size() != 0) report_mismatch("points still outstanding at end");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/epg_pkg.sv
hdl/ellipse_point_generator_top.sv
hdl/epg_checker.sv
bench/testbench.sv
